@@ src/bcss_pkg.sv @@
// ----------------------------------------------------------------------------
// bcss_pkg: shared types and constants of the braking-curve speed supervisor
// Payload structs, sequencer states, end codes and fixed margins.
// ----------------------------------------------------------------------------
package bcss_pkg;

	localparam int SPEED_W = 15;
	localparam int DIST_W  = 13;
	localparam int KMH_W   = 9;
	localparam int DECEL_W = 9;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 15'h7FFF;

	// item modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_END   = 1'b1;

	// end kinds of the previous segment
	localparam logic [1:0] END_JOIN     = 2'd0;
	localparam logic [1:0] END_BUFFER   = 2'd1;
	localparam logic [1:0] END_RED      = 2'd2;
	localparam logic [1:0] END_OVERRIDE = 2'd3;

	// target speeds in km/h
	localparam logic [KMH_W-1:0] STOP_KMH     = 9'd0;
	localparam logic [KMH_W-1:0] OVERRIDE_KMH = 9'd20;

	// km/h to m/s: kmh * 10 / 36, done as (kmh * 10 / 4) / 9
	localparam int KMH_MAX   = 511;
	localparam int KMH_SCALE = 10;
	localparam int KMH_DIV   = 9;

	// 2ad term: a * m * 4^F / 50, done as (a * m * 2^(2F-1)) / 25
	localparam int DECEL_DIV = 25;

	// braking rate and its safety reduction, in 0.01 m/s2
	localparam logic [DECEL_W-1:0] DECEL_RESET   = 9'd50;
	localparam logic [DECEL_W-1:0] DECEL_HI_TH   = 9'd60;
	localparam logic [DECEL_W-1:0] DECEL_HI_CUT  = 9'd20;
	localparam logic [DECEL_W-1:0] DECEL_MID_TH  = 9'd40;
	localparam logic [DECEL_W-1:0] DECEL_MID_CUT = 9'd10;
	localparam logic [DECEL_W-1:0] DECEL_LO_TH   = 9'd10;
	localparam logic [DECEL_W-1:0] DECEL_LO_CUT  = 9'd5;

	// distance margins in meters, as thresholds on the raw distance
	localparam logic [DIST_W-1:0] MARGIN_NEAR_D = 13'd20; // below: no curve
	localparam logic [DIST_W-1:0] MARGIN_MID_D  = 13'd30; // up to: d - 10
	localparam logic [DIST_W-1:0] MARGIN_FAR_D  = 13'd40; // up to: flat 20
	localparam logic [DIST_W-1:0] MARGIN_BASE   = 13'd10;
	localparam logic [DIST_W-1:0] MARGIN_MID_M  = 13'd20;
	localparam logic [DIST_W-1:0] MARGIN_FAR_CUT = 13'd30;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV_MUL,
		ST_CONV_FIX,
		ST_CHECK,
		ST_AM_MUL,
		ST_DIV_MUL,
		ST_DIV_FIX,
		ST_RAD,
		ST_ROOT,
		ST_APPLY,
		ST_WRAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [1:0]        end_kind;
		logic [KMH_W-1:0]  speed_limit_kmh;
		logic [DIST_W-1:0] length_m;
	} seg_t;

	typedef struct packed {
		logic [SPEED_W-1:0] permitted_speed;
		logic [DIST_W-1:0]  lookahead_m;
		logic               done_res;
	} res_t;

endpackage

@@ src/braking_curve_speed_supervisor.sv @@
// ----------------------------------------------------------------------------
// braking_curve_speed_supervisor
// Walks track segments one per transfer, keeps the lowest braking-curve
// speed sqrt(v^2 + 2ad) over all targets and the look-ahead distance.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+------------------------------
//  seg      | seg_valid / seg_ready / seg      | mode, end kind, limit, length
//  res      | res_valid / res_ready / res      | speed, look-ahead, done flag
//  cfg      | cfg_wr_en / cfg_wr_data          | raw braking rate, no wait
//
// Sequence: accept a transfer, then per evaluated target convert, check,
// multiply, divide, form the radicand, run the bit-pair square-root loop
// over R root bits (16 at 6 fraction bits) and apply; one wrap-up step
// after each target and one to hand off. A skipped target goes from check
// to wrap-up, one inside 20 m from check to apply.
// Reset: state cleared, finished set, braking rate back to 0.5 m/s2.
// Stalls: seg_ready is high only while idle. A finished result waits in the
// res register; a new transfer is taken meanwhile, and the next result waits
// in the last sequencer step until res is free.
//
module braking_curve_speed_supervisor #(
	parameter int MAX_LOOKAHEAD   = 5000,
	parameter int SPEED_FRAC_BITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bcss_pkg::DECEL_W-1:0]  cfg_wr_data,
	input  logic                          seg_valid,
	output logic                          seg_ready,
	input  bcss_pkg::seg_t                seg,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bcss_pkg::res_t                res
);

	localparam int SPEED_W = bcss_pkg::SPEED_W;
	localparam int DIST_W  = bcss_pkg::DIST_W;
	localparam int KMH_W   = bcss_pkg::KMH_W;
	localparam int DECEL_W = bcss_pkg::DECEL_W;

	// km/h conversion: n = kmh * 10 * 2^(F-2), speed = n / 9
	localparam int N_MAX = bcss_pkg::KMH_MAX * bcss_pkg::KMH_SCALE * (2 ** (SPEED_FRAC_BITS - 2));
	localparam int N_W   = $clog2(N_MAX + 1);

	// 2ad term: p = a * m, add = (p * 2^S) / 25
	localparam int P_W    = DECEL_W + DIST_W;
	localparam int Q25_W  = P_W - 4;
	localparam int FRAC_SH = 2 * SPEED_FRAC_BITS - 1;

	// shared multiplier operands
	localparam int MOP_W = (N_W > P_W) ? N_W : P_W;
	localparam int PRD_W = 2 * MOP_W;

	// reciprocals for the constant divides, one correction step after
	localparam logic [MOP_W-1:0] RCP9  = MOP_W'((2 ** N_W) / bcss_pkg::KMH_DIV);
	localparam logic [MOP_W-1:0] RCP25 = MOP_W'((2 ** P_W) / bcss_pkg::DECEL_DIV);

	// radicand and root widths
	localparam int SQ_W  = 2 * SPEED_W;
	localparam int ADD_W = Q25_W + FRAC_SH;
	localparam int SUM_W = ((ADD_W > SQ_W) ? ADD_W : SQ_W) + 1;
	localparam int R     = (SUM_W + 1) / 2;
	localparam int X_W   = 2 * R;
	localparam int CNT_W = $clog2(R);

	// speeds below 1.1 m/s are zeroed: curve * 10 < 11 * 2^F
	localparam logic [SPEED_W-1:0] SMALL_SPEED =
		SPEED_W'((11 * (2 ** SPEED_FRAC_BITS) + 9) / 10);

	// fractional part of (r * 2^S) / 25 for remainders 0..24
	typedef logic [FRAC_SH-1:0] frac_tbl_t [bcss_pkg::DECEL_DIV];

	function automatic frac_tbl_t frac_tbl_init();
		frac_tbl_t t;
		for (int i = 0; i < bcss_pkg::DECEL_DIV; i++) begin
			t[i] = FRAC_SH'((i << FRAC_SH) / bcss_pkg::DECEL_DIV);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_TBL = frac_tbl_init();

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	bcss_pkg::state_t      state_q, state_d;
	logic [DECEL_W-1:0]    decel_raw_q;
	logic [SPEED_W-1:0]    speed_now_q;
	logic [DIST_W-1:0]     dist_q;
	logic                  fin_q;
	logic                  pend_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  res_valid_q;
	bcss_pkg::res_t        res_q;

	bcss_pkg::seg_t        item_q;
	logic [KMH_W-1:0]      tgt_kmh_q;
	logic [PRD_W-1:0]      mul_q;
	logic [SPEED_W-1:0]    target_q;
	logic [SQ_W-1:0]       sq_q;
	logic [P_W-1:0]        p_q;
	logic [Q25_W-1:0]      q25_q;
	logic [4:0]            r25_q;
	logic [X_W-1:0]        x_q;
	logic [R:0]            rem_q;
	logic [R-1:0]          root_q;

	// ------------------------------------------------------------------
	// combinational datapath
	// ------------------------------------------------------------------
	logic                  is_start, is_stop, accept, res_load;
	logic                  mul_en;
	logic [MOP_W-1:0]      mul_a, mul_b;
	logic [N_W-1:0]        n_conv, q9, r9, q9c;
	logic [SPEED_W-1:0]    target_d;
	logic [DECEL_W-1:0]    decel_work;
	logic [DIST_W-1:0]     margin_m;
	logic [Q25_W-1:0]      q25, q25c;
	logic [P_W-1:0]        r25;
	logic [R+2:0]          rt_trial, rt_sub, rt_diff;
	logic                  rt_ge;
	logic [SPEED_W-1:0]    curve_sat, curve;
	logic [DIST_W:0]       dist_sum;

	assign is_start = (item_q.mode == bcss_pkg::MODE_START);
	assign is_stop  = (item_q.end_kind == bcss_pkg::END_BUFFER) ||
		(item_q.end_kind == bcss_pkg::END_RED);
	assign accept   = seg_valid && seg_ready;

	// km/h to speed, reciprocal estimate plus one correction
	assign n_conv = (N_W'(tgt_kmh_q) * N_W'(bcss_pkg::KMH_SCALE)) << (SPEED_FRAC_BITS - 2);
	assign q9     = mul_q[N_W +: N_W];
	assign r9     = n_conv - q9 * N_W'(bcss_pkg::KMH_DIV);
	assign q9c    = (r9 >= N_W'(bcss_pkg::KMH_DIV)) ? q9 + N_W'(1) : q9;
	assign target_d = (q9c > N_W'(bcss_pkg::SPEED_MAX)) ? bcss_pkg::SPEED_MAX
		: q9c[SPEED_W-1:0];

	// working braking rate
	always_comb begin
		priority if (decel_raw_q > bcss_pkg::DECEL_HI_TH) begin
			decel_work = decel_raw_q - bcss_pkg::DECEL_HI_CUT;
		end else if (decel_raw_q > bcss_pkg::DECEL_MID_TH) begin
			decel_work = decel_raw_q - bcss_pkg::DECEL_MID_CUT;
		end else if (decel_raw_q > bcss_pkg::DECEL_LO_TH) begin
			decel_work = decel_raw_q - bcss_pkg::DECEL_LO_CUT;
		end else begin
			decel_work = decel_raw_q;
		end
	end

	// distance after margins; only used at 20 m and beyond
	always_comb begin
		priority if (dist_q > bcss_pkg::MARGIN_FAR_D) begin
			margin_m = dist_q - bcss_pkg::MARGIN_FAR_CUT;
		end else if (dist_q > bcss_pkg::MARGIN_MID_D) begin
			margin_m = bcss_pkg::MARGIN_MID_M;
		end else begin
			margin_m = dist_q - bcss_pkg::MARGIN_BASE;
		end
	end

	// p / 25, reciprocal estimate plus one correction
	assign q25  = mul_q[P_W +: Q25_W];
	assign r25  = p_q - P_W'(q25) * P_W'(bcss_pkg::DECEL_DIV);
	assign q25c = (r25 >= P_W'(bcss_pkg::DECEL_DIV)) ? q25 + Q25_W'(1) : q25;

	// one bit-pair step of the restoring square root
	assign rt_trial = {rem_q, x_q[X_W-1 -: 2]};
	assign rt_sub   = {1'b0, root_q, 2'b01};
	assign rt_ge    = (rt_trial >= rt_sub);
	assign rt_diff  = rt_trial - rt_sub;

	// curve speed: saturate, zero the crawl range
	assign curve_sat = (root_q > R'(bcss_pkg::SPEED_MAX)) ? bcss_pkg::SPEED_MAX
		: root_q[SPEED_W-1:0];
	assign curve     = (curve_sat < SMALL_SPEED) ? '0 : curve_sat;

	assign dist_sum = {1'b0, dist_q} + {1'b0, item_q.length_m};

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bcss_pkg::ST_IDLE: begin
				if (accept) begin
					if (seg.mode == bcss_pkg::MODE_END && fin_q) begin
						state_d = bcss_pkg::ST_DONE;
					end else begin
						state_d = bcss_pkg::ST_CONV_MUL;
					end
				end
			end
			bcss_pkg::ST_CONV_MUL: state_d = bcss_pkg::ST_CONV_FIX;
			bcss_pkg::ST_CONV_FIX: state_d = bcss_pkg::ST_CHECK;
			bcss_pkg::ST_CHECK: begin
				priority if (is_start || target_q > speed_now_q) begin
					state_d = bcss_pkg::ST_WRAP;
				end else if (dist_q < bcss_pkg::MARGIN_NEAR_D) begin
					state_d = bcss_pkg::ST_APPLY;
				end else begin
					state_d = bcss_pkg::ST_AM_MUL;
				end
			end
			bcss_pkg::ST_AM_MUL:  state_d = bcss_pkg::ST_DIV_MUL;
			bcss_pkg::ST_DIV_MUL: state_d = bcss_pkg::ST_DIV_FIX;
			bcss_pkg::ST_DIV_FIX: state_d = bcss_pkg::ST_RAD;
			bcss_pkg::ST_RAD:     state_d = bcss_pkg::ST_ROOT;
			bcss_pkg::ST_ROOT: begin
				if (cnt_q == '0) begin
					state_d = bcss_pkg::ST_APPLY;
				end
			end
			bcss_pkg::ST_APPLY:   state_d = bcss_pkg::ST_WRAP;
			bcss_pkg::ST_WRAP: begin
				state_d = pend_q ? bcss_pkg::ST_CONV_MUL : bcss_pkg::ST_DONE;
			end
			bcss_pkg::ST_DONE: begin
				if (res_load) begin
					state_d = bcss_pkg::ST_IDLE;
				end
			end
			default: state_d = bcss_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// control outputs and multiplier operand select
	// ------------------------------------------------------------------
	always_comb begin
		seg_ready = (state_q == bcss_pkg::ST_IDLE);
		res_load  = (state_q == bcss_pkg::ST_DONE) && (!res_valid_q || res_ready);
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			bcss_pkg::ST_CONV_MUL: begin
				mul_en = 1'b1;
				mul_a  = MOP_W'(n_conv);
				mul_b  = RCP9;
			end
			bcss_pkg::ST_CHECK: begin
				mul_en = 1'b1;
				mul_a  = MOP_W'(target_q);
				mul_b  = MOP_W'(target_q);
			end
			bcss_pkg::ST_AM_MUL: begin
				mul_en = 1'b1;
				mul_a  = MOP_W'(decel_work);
				mul_b  = MOP_W'(margin_m);
			end
			bcss_pkg::ST_DIV_MUL: begin
				mul_en = 1'b1;
				mul_a  = MOP_W'(mul_q[P_W-1:0]);
				mul_b  = RCP25;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// control and block state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcss_pkg::ST_IDLE;
			decel_raw_q <= bcss_pkg::DECEL_RESET;
			speed_now_q <= '0;
			dist_q      <= '0;
			fin_q       <= 1'b1;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				decel_raw_q <= cfg_wr_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				bcss_pkg::ST_IDLE: begin
					if (accept) begin
						pend_q <= (seg.mode == bcss_pkg::MODE_END) &&
							(seg.end_kind == bcss_pkg::END_OVERRIDE);
					end
				end
				bcss_pkg::ST_CHECK: begin
					if (is_start) begin
						speed_now_q <= target_q;
					end
				end
				bcss_pkg::ST_RAD: cnt_q <= CNT_W'(R - 1);
				bcss_pkg::ST_ROOT: cnt_q <= cnt_q - CNT_W'(1);
				bcss_pkg::ST_APPLY: begin
					if (curve < speed_now_q) begin
						speed_now_q <= curve;
					end
				end
				bcss_pkg::ST_WRAP: begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else if (is_start) begin
						dist_q <= item_q.length_m;
						fin_q  <= 1'b0;
					end else if (is_stop) begin
						fin_q <= 1'b1;
					end else if (dist_sum > (DIST_W + 1)'(MAX_LOOKAHEAD)) begin
						dist_q <= DIST_W'(MAX_LOOKAHEAD);
						fin_q  <= 1'b1;
					end else begin
						dist_q <= dist_sum[DIST_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		if (res_load) begin
			res_q.permitted_speed <= speed_now_q;
			res_q.lookahead_m     <= dist_q;
			res_q.done_res        <= fin_q;
		end
		unique case (state_q)
			bcss_pkg::ST_IDLE: begin
				if (accept) begin
					item_q <= seg;
					priority if (seg.mode == bcss_pkg::MODE_START) begin
						tgt_kmh_q <= seg.speed_limit_kmh;
					end else if (seg.end_kind == bcss_pkg::END_BUFFER ||
						seg.end_kind == bcss_pkg::END_RED) begin
						tgt_kmh_q <= bcss_pkg::STOP_KMH;
					end else if (seg.end_kind == bcss_pkg::END_OVERRIDE) begin
						tgt_kmh_q <= bcss_pkg::OVERRIDE_KMH;
					end else begin
						tgt_kmh_q <= seg.speed_limit_kmh;
					end
				end
			end
			bcss_pkg::ST_CONV_FIX: target_q <= target_d;
			bcss_pkg::ST_CHECK: root_q <= R'(target_q);
			bcss_pkg::ST_AM_MUL: sq_q <= mul_q[SQ_W-1:0];
			bcss_pkg::ST_DIV_MUL: p_q <= mul_q[P_W-1:0];
			bcss_pkg::ST_DIV_FIX: begin
				q25_q <= q25c;
				r25_q <= (r25 >= P_W'(bcss_pkg::DECEL_DIV))
					? 5'(r25 - P_W'(bcss_pkg::DECEL_DIV)) : 5'(r25);
			end
			bcss_pkg::ST_RAD: begin
				x_q    <= X_W'(sq_q) + X_W'({q25_q, FRAC_TBL[r25_q]});
				rem_q  <= '0;
				root_q <= '0;
			end
			bcss_pkg::ST_ROOT: begin
				x_q    <= x_q << 2;
				rem_q  <= rt_ge ? rt_diff[R:0] : rt_trial[R:0];
				root_q <= {root_q[R-2:0], rt_ge};
			end
			bcss_pkg::ST_WRAP: begin
				if (pend_q) begin
					tgt_kmh_q <= item_q.speed_limit_kmh;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == bcss_pkg::ST_DONE))
		else $error("result raised outside the hand-off step");

	a_speed_rise_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_now_q > $past(speed_now_q)) |->
		$past(state_q == bcss_pkg::ST_CHECK && is_start))
		else $error("permitted speed rose without a start item");

	a_dist_capped: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == bcss_pkg::ST_WRAP && !pend_q && !is_start && !is_stop)
		|-> (dist_q <= DIST_W'(MAX_LOOKAHEAD)))
		else $error("look-ahead above cap after a joining end");

	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bcss_pkg::ST_ROOT) |-> (cnt_q <= CNT_W'(R - 1)))
		else $error("root step count out of range");

endmodule
